/* rtl/core/cds_pkg.sv */
// shared types, constants and calendar tables for the date stepper
package cds_pkg;

	// field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 16;
	localparam int DIST_W  = 22;
	localparam int NUM_W   = 23;
	localparam int QUO_W   = 8;
	localparam int REM_W   = 7;

	// limits
	localparam int MAX_STEP = 65535;
	localparam int MAX_YEAR = 9999;

	// state after reset
	localparam int RESET_DAY   = 1;
	localparam int RESET_MONTH = 1;
	localparam int RESET_YEAR  = 2000;

	// division by 100 through a reciprocal, exact for values below 2**14
	localparam int DIV100_MUL   = 10486;
	localparam int DIV100_SHIFT = 20;
	localparam int PROD_W       = 28;

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_NEXT = 3'd1,
		OP_PREV = 3'd2,
		OP_ADD  = 3'd3,
		OP_SUB  = 3'd4,
		OP_DIST = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARG_WAIT,
		ST_CUR_WAIT,
		ST_STEP,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic num_start;
		logic num_sel_cur;
		logic load_date;
		logic save_arg;
		logic calc_dist;
		logic step_en;
		logic set_err;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic num_done;
		logic num_valid;
		logic op_load;
		logic remain_zero;
		logic at_limit;
		logic out_free;
	} status_t;

	// length of a month, zero for a month code that means nothing
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// days in the year before the first of month m
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [8:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && m > 4'd2) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

/* rtl/core/cds_daynum.sv */
// three-stage day number unit with leap and validity check
module cds_daynum (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cds_pkg::DAY_W-1:0]      day,
	input  logic [cds_pkg::MONTH_W-1:0]    month,
	input  logic [cds_pkg::YEAR_W-1:0]     year,
	output logic                           done,
	output logic                           valid,
	output logic [cds_pkg::NUM_W-1:0]      num,
	output logic [cds_pkg::REM_W-1:0]      rem100,
	output logic [1:0]                     cent4
);

	logic v_s1, v_s2, v_s3;

	logic [cds_pkg::DAY_W-1:0]   day_s1, day_s2;
	logic [cds_pkg::MONTH_W-1:0] month_s1, month_s2;
	logic [cds_pkg::YEAR_W-1:0]  year_s1, p_s1;
	logic [cds_pkg::QUO_W-1:0]   yq_s1, pq_s1, p4q_s1;

	logic [cds_pkg::NUM_W-1:0]   base_s2;
	logic                        leap_s2, ok_s2;
	logic [cds_pkg::REM_W-1:0]   rem_s2;
	logic [1:0]                  c4_s2;

	logic [cds_pkg::NUM_W-1:0]   num_s3;
	logic                        ok_s3;
	logic [cds_pkg::REM_W-1:0]   rem_s3;
	logic [1:0]                  c4_s3;

	// stage 1 quotients by reciprocal multiplication
	logic [cds_pkg::YEAR_W-1:0] p_c;
	logic [cds_pkg::PROD_W-1:0] yprod_c, pprod_c, p4prod_c;

	assign p_c      = year - cds_pkg::YEAR_W'(1);
	assign yprod_c  = cds_pkg::PROD_W'(year) * cds_pkg::PROD_W'(cds_pkg::DIV100_MUL);
	assign pprod_c  = cds_pkg::PROD_W'(p_c) * cds_pkg::PROD_W'(cds_pkg::DIV100_MUL);
	assign p4prod_c = cds_pkg::PROD_W'(p_c[cds_pkg::YEAR_W-1:2])
		* cds_pkg::PROD_W'(cds_pkg::DIV100_MUL);

	// stage 2 leap rule, year base and range test
	logic [cds_pkg::YEAR_W-1:0] rem_wide_c;
	logic [cds_pkg::REM_W-1:0]  rem_c;
	logic                       leap_c, ok_c;
	logic [cds_pkg::NUM_W-1:0]  base_c;
	logic [cds_pkg::DAY_W-1:0]  len_c;

	always_comb begin
		rem_wide_c = year_s1 - cds_pkg::YEAR_W'(yq_s1) * cds_pkg::YEAR_W'(100);
		rem_c      = rem_wide_c[cds_pkg::REM_W-1:0];
		leap_c     = ((year_s1[1:0] == 2'd0) && (rem_c != '0))
			|| ((rem_c == '0) && (yq_s1[1:0] == 2'd0));
		base_c     = cds_pkg::NUM_W'(365) * cds_pkg::NUM_W'(p_s1)
			+ cds_pkg::NUM_W'(p_s1[cds_pkg::YEAR_W-1:2])
			- cds_pkg::NUM_W'(pq_s1)
			+ cds_pkg::NUM_W'(p4q_s1);
		len_c      = cds_pkg::month_len(month_s1, leap_c);
		ok_c       = (year_s1 != '0)
			&& (32'(year_s1) <= 32'(cds_pkg::MAX_YEAR))
			&& (len_c != '0)
			&& (day_s1 != '0)
			&& (day_s1 <= len_c);
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		day_s1   <= day;
		month_s1 <= month;
		year_s1  <= year;
		p_s1     <= p_c;
		yq_s1    <= yprod_c[cds_pkg::DIV100_SHIFT +: cds_pkg::QUO_W];
		pq_s1    <= pprod_c[cds_pkg::DIV100_SHIFT +: cds_pkg::QUO_W];
		p4q_s1   <= p4prod_c[cds_pkg::DIV100_SHIFT +: cds_pkg::QUO_W];

		day_s2   <= day_s1;
		month_s2 <= month_s1;
		base_s2  <= base_c;
		leap_s2  <= leap_c;
		ok_s2    <= ok_c;
		rem_s2   <= rem_c;
		c4_s2    <= yq_s1[1:0];

		num_s3   <= base_s2 + cds_pkg::NUM_W'(cds_pkg::days_before(month_s2, leap_s2))
			+ cds_pkg::NUM_W'(day_s2) - cds_pkg::NUM_W'(1);
		ok_s3    <= ok_s2;
		rem_s3   <= rem_s2;
		c4_s3    <= c4_s2;
	end

	assign done   = v_s3;
	assign valid  = ok_s3;
	assign num    = num_s3;
	assign rem100 = rem_s3;
	assign cent4  = c4_s3;

endmodule

/* rtl/core/cds_datapath.sv */
// date registers, day stepping, distance and result register
module cds_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cds_pkg::cmd_t                  cmd,
	output cds_pkg::status_t               status,
	input  logic [2:0]                     op,
	input  logic [cds_pkg::DAY_W-1:0]      arg_day,
	input  logic [cds_pkg::MONTH_W-1:0]    arg_month,
	input  logic [cds_pkg::YEAR_W-1:0]     arg_year,
	input  logic [cds_pkg::COUNT_W-1:0]    step_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cds_pkg::DAY_W-1:0]      cur_day,
	output logic [cds_pkg::MONTH_W-1:0]    cur_month,
	output logic [cds_pkg::YEAR_W-1:0]     cur_year,
	output logic [cds_pkg::DIST_W-1:0]     day_distance,
	output logic                           range_error
);

	localparam logic [cds_pkg::REM_W-1:0] RESET_REM =
		cds_pkg::REM_W'(cds_pkg::RESET_YEAR % 100);
	localparam logic [1:0] RESET_C4 = 2'((cds_pkg::RESET_YEAR / 100) % 4);
	localparam logic [cds_pkg::REM_W-1:0] REM_TOP = cds_pkg::REM_W'(99);

	// current date and its century position
	logic [cds_pkg::DAY_W-1:0]   date_day_q;
	logic [cds_pkg::MONTH_W-1:0] date_month_q;
	logic [cds_pkg::YEAR_W-1:0]  date_year_q;
	logic [cds_pkg::REM_W-1:0]   rem100_q;
	logic [1:0]                  c4_q;

	// request held while it is worked on
	logic [2:0]                  op_q;
	logic [cds_pkg::COUNT_W-1:0] remain_q;
	logic [cds_pkg::DAY_W-1:0]   req_day_q;
	logic [cds_pkg::MONTH_W-1:0] req_month_q;
	logic [cds_pkg::YEAR_W-1:0]  req_year_q;
	logic [cds_pkg::NUM_W-1:0]   znum_q;
	logic                        err_q;
	logic [cds_pkg::DIST_W-1:0]  dist_q;

	// result register
	logic                        out_valid_q;
	logic [cds_pkg::DAY_W-1:0]   out_day_q;
	logic [cds_pkg::MONTH_W-1:0] out_month_q;
	logic [cds_pkg::YEAR_W-1:0]  out_year_q;
	logic [cds_pkg::DIST_W-1:0]  out_dist_q;
	logic                        out_err_q;

	// day number unit, fed from the request ports or the current date
	logic                        num_done, num_valid;
	logic [cds_pkg::NUM_W-1:0]   num;
	logic [cds_pkg::REM_W-1:0]   num_rem;
	logic [1:0]                  num_c4;

	cds_daynum u_daynum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.num_start),
		.day    (cmd.num_sel_cur ? date_day_q   : arg_day),
		.month  (cmd.num_sel_cur ? date_month_q : arg_month),
		.year   (cmd.num_sel_cur ? date_year_q  : arg_year),
		.done   (num_done),
		.valid  (num_valid),
		.num    (num),
		.rem100 (num_rem),
		.cent4  (num_c4)
	);

	// day count for the request, saturated
	logic [cds_pkg::COUNT_W-1:0] count_c;

	always_comb begin
		if (op == cds_pkg::OP_NEXT || op == cds_pkg::OP_PREV) begin
			count_c = cds_pkg::COUNT_W'(1);
		end else if (32'(step_count) > 32'(cds_pkg::MAX_STEP)) begin
			count_c = cds_pkg::COUNT_W'(cds_pkg::MAX_STEP);
		end else begin
			count_c = step_count;
		end
	end

	// one day forward or back
	logic                        fwd_c, leap_c, at_limit_c;
	logic [cds_pkg::DAY_W-1:0]   nday_c;
	logic [cds_pkg::MONTH_W-1:0] nmonth_c;
	logic [cds_pkg::YEAR_W-1:0]  nyear_c;
	logic [cds_pkg::REM_W-1:0]   nrem_c;
	logic [1:0]                  nc4_c;

	always_comb begin
		fwd_c  = (op_q == cds_pkg::OP_NEXT) || (op_q == cds_pkg::OP_ADD);
		leap_c = ((date_year_q[1:0] == 2'd0) && (rem100_q != '0))
			|| ((rem100_q == '0) && (c4_q == 2'd0));
		if (fwd_c) begin
			at_limit_c = (date_day_q == cds_pkg::DAY_W'(31))
				&& (date_month_q == cds_pkg::MONTH_W'(12))
				&& (32'(date_year_q) == 32'(cds_pkg::MAX_YEAR));
		end else begin
			at_limit_c = (date_day_q == cds_pkg::DAY_W'(1))
				&& (date_month_q == cds_pkg::MONTH_W'(1))
				&& (date_year_q == cds_pkg::YEAR_W'(1));
		end

		nday_c   = date_day_q;
		nmonth_c = date_month_q;
		nyear_c  = date_year_q;
		nrem_c   = rem100_q;
		nc4_c    = c4_q;
		if (fwd_c) begin
			if (date_day_q == cds_pkg::month_len(date_month_q, leap_c)) begin
				nday_c = cds_pkg::DAY_W'(1);
				if (date_month_q == cds_pkg::MONTH_W'(12)) begin
					nmonth_c = cds_pkg::MONTH_W'(1);
					nyear_c  = date_year_q + cds_pkg::YEAR_W'(1);
					if (rem100_q == REM_TOP) begin
						nrem_c = '0;
						nc4_c  = c4_q + 2'd1;
					end else begin
						nrem_c = rem100_q + cds_pkg::REM_W'(1);
					end
				end else begin
					nmonth_c = date_month_q + cds_pkg::MONTH_W'(1);
				end
			end else begin
				nday_c = date_day_q + cds_pkg::DAY_W'(1);
			end
		end else begin
			if (date_day_q == cds_pkg::DAY_W'(1)) begin
				if (date_month_q == cds_pkg::MONTH_W'(1)) begin
					nday_c   = cds_pkg::DAY_W'(31);
					nmonth_c = cds_pkg::MONTH_W'(12);
					nyear_c  = date_year_q - cds_pkg::YEAR_W'(1);
					if (rem100_q == '0) begin
						nrem_c = REM_TOP;
						nc4_c  = c4_q - 2'd1;
					end else begin
						nrem_c = rem100_q - cds_pkg::REM_W'(1);
					end
				end else begin
					nmonth_c = date_month_q - cds_pkg::MONTH_W'(1);
					nday_c   = cds_pkg::month_len(nmonth_c, leap_c);
				end
			end else begin
				nday_c = date_day_q - cds_pkg::DAY_W'(1);
			end
		end
	end

	// absolute distance, saturated to the field
	logic [cds_pkg::NUM_W-1:0]  diff_c;
	logic [cds_pkg::DIST_W-1:0] dist_c;

	always_comb begin
		diff_c = (num > znum_q) ? (num - znum_q) : (znum_q - num);
		if (diff_c[cds_pkg::NUM_W-1]) begin
			dist_c = '1;
		end else begin
			dist_c = diff_c[cds_pkg::DIST_W-1:0];
		end
	end

	// date and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_day_q   <= cds_pkg::DAY_W'(cds_pkg::RESET_DAY);
			date_month_q <= cds_pkg::MONTH_W'(cds_pkg::RESET_MONTH);
			date_year_q  <= cds_pkg::YEAR_W'(cds_pkg::RESET_YEAR);
			rem100_q     <= RESET_REM;
			c4_q         <= RESET_C4;
			op_q         <= cds_pkg::OP_LOAD;
			remain_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.capture) begin
				op_q     <= op;
				remain_q <= count_c;
			end
			if (cmd.load_date) begin
				date_day_q   <= req_day_q;
				date_month_q <= req_month_q;
				date_year_q  <= req_year_q;
				rem100_q     <= num_rem;
				c4_q         <= num_c4;
			end
			if (cmd.step_en) begin
				date_day_q   <= nday_c;
				date_month_q <= nmonth_c;
				date_year_q  <= nyear_c;
				rem100_q     <= nrem_c;
				c4_q         <= nc4_c;
				remain_q     <= remain_q - cds_pkg::COUNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request payload and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_day_q   <= arg_day;
			req_month_q <= arg_month;
			req_year_q  <= arg_year;
			err_q       <= 1'b0;
			dist_q      <= '0;
		end
		if (cmd.save_arg) begin
			znum_q <= num;
		end
		if (cmd.calc_dist) begin
			dist_q <= dist_c;
		end
		if (cmd.set_err) begin
			err_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_day_q   <= date_day_q;
			out_month_q <= date_month_q;
			out_year_q  <= date_year_q;
			out_dist_q  <= dist_q;
			out_err_q   <= err_q;
		end
	end

	assign status.num_done    = num_done;
	assign status.num_valid   = num_valid;
	assign status.op_load     = (op_q == cds_pkg::OP_LOAD);
	assign status.remain_zero = (remain_q == '0);
	assign status.at_limit    = at_limit_c;
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign cur_day      = out_day_q;
	assign cur_month    = out_month_q;
	assign cur_year     = out_year_q;
	assign day_distance = out_dist_q;
	assign range_error  = out_err_q;

endmodule

/* rtl/core/cds_ctrl.sv */
// controller state machine sequencing each request
module cds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        op,
	input  cds_pkg::status_t  status,
	output cds_pkg::cmd_t     cmd
);

	cds_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			cds_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (cds_pkg::op_t'(op))
						cds_pkg::OP_LOAD, cds_pkg::OP_DIST: begin
							cmd.num_start = 1'b1;
							state_d       = cds_pkg::ST_ARG_WAIT;
						end
						cds_pkg::OP_NEXT, cds_pkg::OP_PREV,
						cds_pkg::OP_ADD, cds_pkg::OP_SUB: begin
							state_d = cds_pkg::ST_STEP;
						end
						default: begin
							state_d = cds_pkg::ST_FINISH;
						end
					endcase
				end
			end
			cds_pkg::ST_ARG_WAIT: begin
				if (status.num_done) begin
					if (!status.num_valid) begin
						cmd.set_err = 1'b1;
						state_d     = cds_pkg::ST_FINISH;
					end else if (status.op_load) begin
						cmd.load_date = 1'b1;
						state_d       = cds_pkg::ST_FINISH;
					end else begin
						// operand is good, now number the current date
						cmd.save_arg    = 1'b1;
						cmd.num_start   = 1'b1;
						cmd.num_sel_cur = 1'b1;
						state_d         = cds_pkg::ST_CUR_WAIT;
					end
				end
			end
			cds_pkg::ST_CUR_WAIT: begin
				if (status.num_done) begin
					cmd.calc_dist = 1'b1;
					state_d       = cds_pkg::ST_FINISH;
				end
			end
			cds_pkg::ST_STEP: begin
				if (status.remain_zero) begin
					state_d = cds_pkg::ST_FINISH;
				end else if (status.at_limit) begin
					cmd.set_err = 1'b1;
					state_d     = cds_pkg::ST_FINISH;
				end else begin
					cmd.step_en = 1'b1;
				end
			end
			cds_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = cds_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cds_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/calendar_date_stepper.sv */
// top level of the gregorian date stepper
//
// channel   direction  handshake              payload
// request   in         in_valid / in_ready    op, arg_day, arg_month, arg_year, step_count
// result    out        out_valid / out_ready  cur_day, cur_month, cur_year, day_distance,
//                                             range_error
//
// one request at a time; day steps move one day per cycle in the stepping loop, which
// a year limit can stop early; load and distance wait on the three-stage day number
// unit
// reset returns the date to 1 january 2000 and empties the result register
// a request is taken while the last result waits; a stalled result holds the next one
// in its finishing state until the result register frees
module calendar_date_stepper (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     op,
	input  logic [cds_pkg::DAY_W-1:0]      arg_day,
	input  logic [cds_pkg::MONTH_W-1:0]    arg_month,
	input  logic [cds_pkg::YEAR_W-1:0]     arg_year,
	input  logic [cds_pkg::COUNT_W-1:0]    step_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cds_pkg::DAY_W-1:0]      cur_day,
	output logic [cds_pkg::MONTH_W-1:0]    cur_month,
	output logic [cds_pkg::YEAR_W-1:0]     cur_year,
	output logic [cds_pkg::DIST_W-1:0]     day_distance,
	output logic                           range_error
);

	cds_pkg::cmd_t    cmd;
	cds_pkg::status_t status;

	// sequencing
	cds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.status   (status),
		.cmd      (cmd)
	);

	// date state and arithmetic
	cds_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.op           (op),
		.arg_day      (arg_day),
		.arg_month    (arg_month),
		.arg_year     (arg_year),
		.step_count   (step_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cur_day      (cur_day),
		.cur_month    (cur_month),
		.cur_year     (cur_year),
		.day_distance (day_distance),
		.range_error  (range_error)
	);

endmodule
